@@ rtl/core/assert_macros.svh @@
// Assertion macros for the YOLO candidate decoder RTL.
// Include by bare file name; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is active.
`define YCD_ASSERT_NOW(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error("yolo_candidate_decode: assertion failed");

// Next-cycle implication, disabled while reset is active.
`define YCD_ASSERT_NEXT(lbl, clk_s, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("yolo_candidate_decode: assertion failed");

`endif

@@ rtl/core/ycd_pkg.sv @@
// Package for the YOLO candidate decoder: field widths, register codes,
// reset values and parameter defaults. No dependencies.
package ycd_pkg;

	localparam int VALUE_W     = 32;
	localparam int CLS_IDX_W   = 10;
	localparam int CONF_W      = 31;
	localparam int CFG_W       = 17;
	localparam int CFG_IDX_W   = 2;
	localparam int NCLS_W      = 11;

	localparam int DEF_MAX_CLASSES       = 1024;
	localparam int DEF_ANCHOR_INDEX_BITS = 18;

	// columns ahead of the class scores: four box values, plus objectness
	localparam int BOX_COLS        = 4;
	localparam int HEAD_COLS_PLAIN = 4;
	localparam int HEAD_COLS_ANCH  = 5;

	localparam logic [CFG_W-1:0]  RST_CONF_THR    = 17'd16384;
	localparam logic [NCLS_W-1:0] RST_NUM_CLASSES = 11'd16;
	localparam logic              RST_ANCHOR_MODE = 1'b0;
	localparam logic              RST_C2C         = 1'b1;

	localparam logic [CONF_W-1:0] CONF_MAX = {CONF_W{1'b1}};

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CONF_THRESHOLD   = 2'd0,
		CFG_NUM_CLASSES      = 2'd1,
		CFG_ANCHOR_BASED     = 2'd2,
		CFG_CENTER_TO_CORNER = 2'd3
	} cfg_reg_t;

endpackage

@@ rtl/core/yolo_candidate_decode_top.sv @@
// YOLO candidate decoder top level: streams Q16.16 detector rows in and
// emits kept detection candidates. Depends on ycd_pkg and assert_macros.svh.
//
// Usage:
//  - Input stream (s_*): one signed Q16.16 row element per request in
//    s_tdata; s_tuser marks the first element of a frame, which restarts
//    the column and anchor counts. A row is cx, cy, w, h, objectness (when
//    anchor_based is set), then num_classes class scores.
//  - Output stream (m_*): one candidate per kept row, carrying anchor index,
//    first arg-max class, confidence and the box (corner or centre form).
//  - Configuration: cfg_we writes cfg_wdata to the register cfg_index
//    selects, in the same edge. Write only while no row is in flight.
//  - Throughput: one element per cycle while s_tready is high, bounded by
//    the column/max update loop on the row state. The objectness product
//    sits in a stage of its own, so the loop holds only one 32-bit compare.
//  - Output path: the last element of a row enters the input register; the
//    row record then passes the row, product and output regs to m_tvalid.
//  - Stall: each stage advances only into an empty or draining stage, so
//    m_tready held low fills the pipeline before s_tready drops.
//  - Reset: clears counters, row state, stage valids and restores the
//    register reset values (threshold 0.25, 16 classes, corner form).
`include "assert_macros.svh"

module yolo_candidate_decode_top
	import ycd_pkg::*;
#(
	parameter int MAX_CLASSES       = DEF_MAX_CLASSES,
	parameter int ANCHOR_INDEX_BITS = DEF_ANCHOR_INDEX_BITS,
	localparam int OUT_BITS = ANCHOR_INDEX_BITS + CLS_IDX_W + CONF_W + 4 * VALUE_W,
	localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// input stream
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [VALUE_W-1:0]   s_tdata,   // [31:0] value
	input  logic [0:0]           s_tuser,   // [0] first_of_frame
	// output stream
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// from bit 0: anchor_index, best class, confidence, box_x, box_y, box_w,
	// box_h, zero fill
	output logic [OUT_W-1:0]     m_tdata,
	// configuration writes
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int COL_W  = $clog2(MAX_CLASSES + HEAD_COLS_ANCH);
	localparam int CIDX_W = (MAX_CLASSES > 1) ? $clog2(MAX_CLASSES) : 1;
	localparam int NW     = (COL_W > NCLS_W) ? COL_W : NCLS_W;
	localparam int AIB    = ANCHOR_INDEX_BITS;

	// configuration registers
	logic [CFG_W-1:0]  conf_thr_q;
	logic [NCLS_W-1:0] num_classes_q;
	logic              anchor_mode_q;
	logic              c2c_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			conf_thr_q    <= RST_CONF_THR;
			num_classes_q <= RST_NUM_CLASSES;
			anchor_mode_q <= RST_ANCHOR_MODE;
			c2c_q         <= RST_C2C;
		end else if (cfg_we) begin
			case (cfg_reg_t'(cfg_index))
				CFG_CONF_THRESHOLD:   conf_thr_q    <= cfg_wdata;
				CFG_NUM_CLASSES:      num_classes_q <= cfg_wdata[NCLS_W-1:0];
				CFG_ANCHOR_BASED:     anchor_mode_q <= cfg_wdata[0];
				CFG_CENTER_TO_CORNER: c2c_q         <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// stage handshake: each stage loads when it is empty or moving on
	logic s1_v, s2_v, s3_v, out_v;
	logic s1_rdy, s2_rdy, s3_rdy, o_rdy;
	logic s1_fire, row_end, keep;

	assign o_rdy    = !out_v || m_tready;
	assign s3_rdy   = !s3_v || o_rdy;
	assign s2_rdy   = !s2_v || s3_rdy;
	assign s1_rdy   = !s1_v || s2_rdy;
	assign s1_fire  = s1_v && s2_rdy;
	assign s_tready = s1_rdy;
	assign m_tvalid = out_v;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v  <= 1'b0;
			s2_v  <= 1'b0;
			s3_v  <= 1'b0;
			out_v <= 1'b0;
		end else begin
			if (s1_rdy) s1_v  <= s_tvalid;
			if (s2_rdy) s2_v  <= s1_v && row_end;
			if (s3_rdy) s3_v  <= s2_v;
			if (o_rdy)  out_v <= s3_v && keep;
		end
	end

	// input register
	logic signed [VALUE_W-1:0] value_s1;
	logic                      fof_s1;

	always_ff @(posedge clk) begin
		if (s1_rdy && s_tvalid) begin
			value_s1 <= s_tdata;
			fof_s1   <= s_tuser[0];
		end
	end

	// row state
	logic [COL_W-1:0]          column_count_q;
	logic [AIB-1:0]            anchor_count_q;
	logic signed [VALUE_W-1:0] box_q [BOX_COLS];
	logic signed [VALUE_W-1:0] obj_q;
	logic signed [VALUE_W-1:0] best_q;
	logic [CIDX_W-1:0]         best_cls_q;

	logic [COL_W-1:0]          col, base, last, k_full, n_eff;
	logic [NW-1:0]             ncls_w, n_eff_w;
	logic [AIB-1:0]            anchor_cur;
	logic signed [VALUE_W-1:0] box_n [BOX_COLS];
	logic signed [VALUE_W-1:0] obj_n, best_n;
	logic [CIDX_W-1:0]         cls_n;

	always_comb begin
		// frame start restarts both counts on this element
		col        = fof_s1 ? '0 : column_count_q;
		anchor_cur = fof_s1 ? '0 : anchor_count_q;
		base       = anchor_mode_q ? COL_W'(HEAD_COLS_ANCH) : COL_W'(HEAD_COLS_PLAIN);

		// clamp the class count to 1..MAX_CLASSES
		ncls_w = NW'(num_classes_q);
		if (ncls_w == '0)
			n_eff_w = NW'(1);
		else if (ncls_w > NW'(MAX_CLASSES))
			n_eff_w = NW'(MAX_CLASSES);
		else
			n_eff_w = ncls_w;
		n_eff   = n_eff_w[COL_W-1:0];
		last    = base + n_eff - COL_W'(1);
		row_end = (col >= last);
		k_full  = col - base;

		box_n  = box_q;
		obj_n  = obj_q;
		best_n = best_q;
		cls_n  = best_cls_q;
		if (col < COL_W'(BOX_COLS)) begin
			box_n[col[1:0]] = value_s1;
		end else if (anchor_mode_q && col == COL_W'(BOX_COLS)) begin
			obj_n = value_s1;
		end else if (col >= base) begin
			// strict compare keeps the first class on ties
			if (k_full == '0 || value_s1 > best_q) begin
				best_n = value_s1;
				cls_n  = CIDX_W'(k_full);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			anchor_count_q <= '0;
			for (int i = 0; i < BOX_COLS; i++) box_q[i] <= '0;
			obj_q      <= '0;
			best_q     <= '0;
			best_cls_q <= '0;
		end else if (s1_fire) begin
			box_q      <= box_n;
			obj_q      <= obj_n;
			best_q     <= best_n;
			best_cls_q <= cls_n;
			if (row_end) begin
				column_count_q <= '0;
				anchor_count_q <= anchor_cur + AIB'(1);
			end else begin
				column_count_q <= col + COL_W'(1);
				anchor_count_q <= anchor_cur;
			end
		end
	end

	// row record at end of row
	logic [AIB-1:0]            anchor_s2;
	logic [CIDX_W-1:0]         cls_s2;
	logic signed [VALUE_W-1:0] best_s2, obj_s2;
	logic signed [VALUE_W-1:0] box_s2 [BOX_COLS];

	always_ff @(posedge clk) begin
		if (s1_fire && row_end) begin
			anchor_s2 <= anchor_cur;
			cls_s2    <= cls_n;
			best_s2   <= best_n;
			obj_s2    <= obj_n;
			box_s2    <= box_n;
		end
	end

	// product and corner stage
	logic signed [2*VALUE_W-1:0] prod;
	logic signed [VALUE_W:0]     dx, dy;
	logic signed [VALUE_W-1:0]   bx_n, by_n;

	always_comb begin
		prod = best_s2 * obj_s2;
		dx   = (VALUE_W+1)'(box_s2[0]) - (VALUE_W+1)'(box_s2[2] >>> 1);
		dy   = (VALUE_W+1)'(box_s2[1]) - (VALUE_W+1)'(box_s2[3] >>> 1);
		if (!c2c_q)
			bx_n = box_s2[0];
		else if (dx[VALUE_W] != dx[VALUE_W-1])
			bx_n = dx[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
		else
			bx_n = dx[VALUE_W-1:0];
		if (!c2c_q)
			by_n = box_s2[1];
		else if (dy[VALUE_W] != dy[VALUE_W-1])
			by_n = dy[VALUE_W] ? {1'b1, {(VALUE_W-1){1'b0}}} : {1'b0, {(VALUE_W-1){1'b1}}};
		else
			by_n = dy[VALUE_W-1:0];
	end

	logic [AIB-1:0]              anchor_s3;
	logic [CIDX_W-1:0]           cls_s3;
	logic signed [VALUE_W-1:0]   best_s3, obj_s3, bx_s3, by_s3, bw_s3, bh_s3;
	logic signed [2*VALUE_W-1:0] prod_s3;

	always_ff @(posedge clk) begin
		if (s3_rdy && s2_v) begin
			anchor_s3 <= anchor_s2;
			cls_s3    <= cls_s2;
			best_s3   <= best_s2;
			obj_s3    <= obj_s2;
			prod_s3   <= prod;
			bx_s3     <= bx_n;
			by_s3     <= by_n;
			bw_s3     <= box_s2[2];
			bh_s3     <= box_s2[3];
		end
	end

	// threshold and saturation
	localparam int CW = 2 * VALUE_W - 16;
	logic signed [CW-1:0]    conf, thr_c;
	logic signed [VALUE_W:0] thr_o;
	logic                    obj_ok;
	logic [CONF_W-1:0]       conf_sat;

	always_comb begin
		thr_c  = $signed(CW'(conf_thr_q));
		thr_o  = $signed((VALUE_W+1)'(conf_thr_q));
		// arithmetic shift of the product is the floor
		conf   = anchor_mode_q ? $signed(prod_s3[2*VALUE_W-1:16]) : CW'(best_s3);
		obj_ok = !anchor_mode_q || ((VALUE_W+1)'(obj_s3) >= thr_o);
		keep   = obj_ok && (conf >= thr_c);
		if (conf > $signed(CW'(CONF_MAX)))
			conf_sat = CONF_MAX;
		else
			conf_sat = conf[CONF_W-1:0];
	end

	logic [OUT_BITS-1:0] res_n;
	assign res_n = {bh_s3, bw_s3, by_s3, bx_s3, conf_sat, CLS_IDX_W'(cls_s3), anchor_s3};

	always_ff @(posedge clk) begin
		if (o_rdy && s3_v && keep) m_tdata <= OUT_W'(res_n);
	end

	// checks
	`YCD_ASSERT_NOW(a_full_when_stalled, clk, arst_n, !s_tready, s1_v && s2_v && s3_v && out_v)
	`YCD_ASSERT_NOW(a_conf_meets_thr, clk, arst_n, m_tvalid,
		m_tdata[AIB+CLS_IDX_W +: CONF_W] >= CONF_W'(conf_thr_q))
	`YCD_ASSERT_NEXT(a_anchor_mid_row, clk, arst_n, s1_fire && !row_end,
		anchor_count_q == $past(anchor_cur))

endmodule
